/* rtl/rrqs_pkg.sv */
// Types and constants shared by the round robin quantum scheduler.
`default_nettype none

package rrqs_pkg;

  localparam int QUANTUM_W = 16;
  localparam logic [QUANTUM_W-1:0] QUANTUM_INIT = 16'd10;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_ADD      = 3'd1,
    REQ_REMOVE   = 3'd2,
    REQ_SET_RUN  = 3'd3,
    REQ_PICK     = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH_ID,
    S_SRCH_CHK,
    S_FIND,
    S_SHIFT,
    S_FIXUP,
    S_HEAD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] task_id;
    logic       runnable_value;
  } req_t;

  typedef struct packed {
    logic [7:0]  chosen_id;
    logic        chosen_valid;
    logic [7:0]  current_id;
    logic        current_valid;
    logic [31:0] ticks_seen;
    logic [4:0]  entries_used;
    logic [1:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/rrqs_flags.sv */
// Runnable flag memory, one bit per task id, cleared by a sweep after reset.
`default_nettype none

module rrqs_flags #(
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [ID_BITS-1:0] wr_addr,
  input  logic               wr_data,
  input  logic [ID_BITS-1:0] rd_addr,
  output logic               rd_data,
  output logic               ready
);

  localparam int DEPTH = 1 << ID_BITS;

  logic               flags [DEPTH];
  logic               clearing;
  logic [ID_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ID_BITS'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      flags[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      flags[wr_addr] <= wr_data;
    end
    rd_data <= flags[rd_addr];
  end

  assign ready = ~clearing;

endmodule

`default_nettype wire

/* rtl/round_robin_quantum_scheduler.sv */
// Top level of the round robin task scheduler with a time quantum.
`default_nettype none

// One request word in, one response word out. After reset the runnable
// flags are swept clear, and no request is taken during the sweep.
// Ticks that do not switch, add, set runnable and unknown requests pass
// through S_EXEC and S_RESULT to the response register. A switching tick and
// pick next walk the task list through the slot memory and the flag memory,
// visiting S_SRCH_ID and S_SRCH_CHK for each entry examined. Remove
// scans for the id at one entry a cycle, shifts the tail down at one entry
// a cycle and may read the new head in S_HEAD.
// The block returns to S_IDLE before the next request is taken.
// A new request is accepted while the previous response still waits.
module round_robin_quantum_scheduler #(
  parameter int MAX_SLOTS = 16,
  parameter int ID_BITS   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  rrqs_pkg::req_t                 req_word,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output rrqs_pkg::rsp_t                 rsp_word,
  input  logic                           cfg_wr_en,
  input  logic [rrqs_pkg::QUANTUM_W-1:0] cfg_wr_data
);

  import rrqs_pkg::*;

  localparam int SLOT_AW = $clog2(MAX_SLOTS);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]     slot_count, slot_count_next;
  logic [SLOT_AW-1:0]   cursor, cursor_next;
  logic [QUANTUM_W-1:0] quantum_left, quantum_left_next;
  logic [QUANTUM_W-1:0] quantum_reload;
  logic [ID_BITS-1:0]   current_task, current_task_next;
  logic                 current_present, current_present_next;
  logic [31:0]          tick_counter, tick_counter_next;
  logic                 rsp_valid_next;
  rsp_t                 rsp_word_next;

  logic [2:0]           req_kind;
  logic [ID_BITS-1:0]   req_id;
  logic                 req_val;
  logic [SLOT_AW-1:0]   idx, idx_next;
  logic [CNT_W-1:0]     left, left_next;
  logic [SLOT_AW-1:0]   hit, hit_next;
  logic [ID_BITS-1:0]   cand_id, cand_id_next;
  logic [ID_BITS-1:0]   res_chosen, res_chosen_next;
  logic                 res_ok, res_ok_next;
  status_t              res_status, res_status_next;

  logic [ID_BITS-1:0]   slots [MAX_SLOTS];
  logic [ID_BITS-1:0]   slot_rdata;
  logic [SLOT_AW-1:0]   slot_rd_addr;
  logic                 slot_we;
  logic [SLOT_AW-1:0]   slot_wr_addr;
  logic [ID_BITS-1:0]   slot_wr_data;

  logic                 flag_we;
  logic                 flag_rdata;
  logic                 flags_ready;

  logic [CNT_W-1:0]     cur_inc, idx_inc, idx_inc2, cnt_dec;
  logic [SLOT_AW-1:0]   cur_wrap, idx_wrap, cur_adj, cur_fix;
  logic [QUANTUM_W-1:0] quantum_dec;
  logic                 accept;

  rrqs_flags #(
    .ID_BITS (ID_BITS)
  ) u_flags (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (flag_we),
    .wr_addr (req_id),
    .wr_data (req_val),
    .rd_addr (slot_rdata),
    .rd_data (flag_rdata),
    .ready   (flags_ready)
  );

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slots[slot_wr_addr] <= slot_wr_data;
    end
    slot_rdata <= slots[slot_rd_addr];
  end

  assign req_ready = (state == S_IDLE) && flags_ready;
  assign accept    = req_valid && req_ready;

  assign cur_inc  = CNT_W'(cursor) + CNT_W'(1);
  assign cur_wrap = (cur_inc == slot_count) ? '0 : SLOT_AW'(cur_inc);
  assign idx_inc  = CNT_W'(idx) + CNT_W'(1);
  assign idx_inc2 = CNT_W'(idx) + CNT_W'(2);
  assign idx_wrap = (idx_inc == slot_count) ? '0 : SLOT_AW'(idx_inc);
  assign cnt_dec  = slot_count - CNT_W'(1);
  assign quantum_dec = (quantum_left != '0) ? quantum_left - QUANTUM_W'(1) : '0;

  always_comb begin
    if (cursor == hit) begin
      cur_adj = '0;
    end else if (cursor > hit) begin
      cur_adj = cursor - SLOT_AW'(1);
    end else begin
      cur_adj = cursor;
    end
    cur_fix = (CNT_W'(cur_adj) >= cnt_dec) ? '0 : cur_adj;
  end

  always_comb begin
    state_next           = state;
    slot_count_next      = slot_count;
    cursor_next          = cursor;
    quantum_left_next    = quantum_left;
    current_task_next    = current_task;
    current_present_next = current_present;
    tick_counter_next    = tick_counter;
    idx_next             = idx;
    left_next            = left;
    hit_next             = hit;
    cand_id_next         = cand_id;
    res_chosen_next      = res_chosen;
    res_ok_next          = res_ok;
    res_status_next      = res_status;
    slot_rd_addr         = '0;
    slot_we              = 1'b0;
    slot_wr_addr         = idx;
    slot_wr_data         = slot_rdata;
    flag_we              = 1'b0;
    rsp_valid_next       = rsp_valid && !rsp_ready;
    rsp_word_next        = rsp_word;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_chosen_next = '0;
        res_ok_next     = 1'b0;
        res_status_next = STAT_OK;
        state_next      = S_RESULT;
        case (req_kind)
          REQ_TICK: begin
            tick_counter_next = tick_counter + 32'd1;
            if (quantum_dec != '0 || slot_count == '0) begin
              quantum_left_next = quantum_dec;
              res_chosen_next   = current_task;
              res_ok_next       = current_present;
            end else begin
              quantum_left_next = quantum_reload;
              slot_rd_addr      = cur_wrap;
              idx_next          = cur_wrap;
              left_next         = slot_count;
              state_next        = S_SRCH_ID;
            end
          end
          REQ_PICK: begin
            if (slot_count != '0) begin
              slot_rd_addr = cur_wrap;
              idx_next     = cur_wrap;
              left_next    = slot_count;
              state_next   = S_SRCH_ID;
            end
          end
          REQ_ADD: begin
            if (slot_count >= CNT_W'(MAX_SLOTS)) begin
              res_status_next = STAT_FULL;
            end else begin
              slot_we         = 1'b1;
              slot_wr_addr    = SLOT_AW'(slot_count);
              slot_wr_data    = req_id;
              slot_count_next = slot_count + CNT_W'(1);
              if (slot_count == '0) begin
                current_task_next    = req_id;
                current_present_next = 1'b1;
              end
            end
          end
          REQ_REMOVE: begin
            if (slot_count == '0) begin
              res_status_next = STAT_NOT_FOUND;
            end else begin
              slot_rd_addr = '0;
              idx_next     = '0;
              state_next   = S_FIND;
            end
          end
          REQ_SET_RUN: begin
            flag_we = 1'b1;
          end
          default: begin
          end
        endcase
      end

      S_SRCH_ID: begin
        cand_id_next = slot_rdata;
        state_next   = S_SRCH_CHK;
      end

      S_SRCH_CHK: begin
        if (flag_rdata) begin
          cursor_next     = idx;
          res_chosen_next = cand_id;
          res_ok_next     = 1'b1;
          if (req_kind == REQ_TICK) begin
            current_task_next    = cand_id;
            current_present_next = 1'b1;
          end
          state_next = S_RESULT;
        end else if (left == CNT_W'(1)) begin
          state_next = S_RESULT;
        end else begin
          left_next    = left - CNT_W'(1);
          idx_next     = idx_wrap;
          slot_rd_addr = idx_wrap;
          state_next   = S_SRCH_ID;
        end
      end

      S_FIND: begin
        if (slot_rdata == req_id) begin
          hit_next = idx;
          if (idx_inc < slot_count) begin
            slot_rd_addr = SLOT_AW'(idx_inc);
            state_next   = S_SHIFT;
          end else begin
            state_next = S_FIXUP;
          end
        end else if (idx_inc >= slot_count) begin
          res_status_next = STAT_NOT_FOUND;
          state_next      = S_RESULT;
        end else begin
          slot_rd_addr = SLOT_AW'(idx_inc);
          idx_next     = SLOT_AW'(idx_inc);
        end
      end

      S_SHIFT: begin
        slot_we      = 1'b1;
        slot_wr_addr = idx;
        slot_wr_data = slot_rdata;
        if (idx_inc2 < slot_count) begin
          slot_rd_addr = SLOT_AW'(idx_inc2);
          idx_next     = SLOT_AW'(idx_inc);
        end else begin
          state_next = S_FIXUP;
        end
      end

      S_FIXUP: begin
        slot_count_next = cnt_dec;
        cursor_next     = cur_fix;
        state_next      = S_RESULT;
        if (current_present && current_task == req_id) begin
          if (cnt_dec != '0) begin
            slot_rd_addr = '0;
            state_next   = S_HEAD;
          end else begin
            current_task_next    = '0;
            current_present_next = 1'b0;
          end
        end
      end

      S_HEAD: begin
        current_task_next = slot_rdata;
        state_next        = S_RESULT;
      end

      S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next              = 1'b1;
          rsp_word_next.chosen_id     = 8'(res_chosen);
          rsp_word_next.chosen_valid  = res_ok;
          rsp_word_next.current_id    = 8'(current_task);
          rsp_word_next.current_valid = current_present;
          rsp_word_next.ticks_seen    = tick_counter;
          rsp_word_next.entries_used  = 5'(slot_count);
          rsp_word_next.status        = res_status;
          state_next                  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      slot_count      <= '0;
      cursor          <= '0;
      quantum_left    <= QUANTUM_INIT;
      quantum_reload  <= QUANTUM_INIT;
      current_task    <= '0;
      current_present <= 1'b0;
      tick_counter    <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      slot_count      <= slot_count_next;
      cursor          <= cursor_next;
      quantum_left    <= quantum_left_next;
      current_task    <= current_task_next;
      current_present <= current_present_next;
      tick_counter    <= tick_counter_next;
      rsp_valid       <= rsp_valid_next;
      if (cfg_wr_en) begin
        quantum_reload <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= req_word.req_type;
      req_id   <= ID_BITS'(req_word.task_id);
      req_val  <= req_word.runnable_value;
    end
    idx        <= idx_next;
    left       <= left_next;
    hit        <= hit_next;
    cand_id    <= cand_id_next;
    res_chosen <= res_chosen_next;
    res_ok     <= res_ok_next;
    res_status <= res_status_next;
    rsp_word   <= rsp_word_next;
  end

endmodule

`default_nettype wire
